// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define CQWS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition leads to a consequence in the next cycle
`define CQWS_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cqws_pkg.sv =====
`timescale 1ns / 1ps

package cqws_pkg;

	localparam int DataWidth  = 16;
	localparam int CountWidth = 7;
	localparam int CapWidth   = 7;
	localparam int DefDepth   = 64;

	// operation codes carried in the mode field
	typedef enum logic [2:0] {
		MODE_ENQ       = 3'd0,
		MODE_DEQ       = 3'd1,
		MODE_POP       = 3'd2,
		MODE_SUM_FRONT = 3'd3,
		MODE_SUM_REAR  = 3'd4,
		MODE_RD_POS    = 3'd5,
		MODE_WR_POS    = 3'd6,
		MODE_SET_LEN   = 3'd7
	} mode_t;

	typedef struct packed {
		mode_t                 mode;
		logic [DataWidth-1:0]  value;
		logic [CountWidth-1:0] count;
	} in_item_t;

	typedef struct packed {
		logic [DataWidth-1:0]  data;
		logic                  ok;
		logic [CountWidth-1:0] length;
		logic                  empty_res;
		logic                  full_res;
	} out_item_t;

endpackage

// ===== rtl/cqws_ram.sv =====
`timescale 1ns / 1ps

module cqws_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/circular_queue_window_sum_unit.sv =====
// flow: an accepted item goes to the execute state; dequeue, pop, read and window
// sums that are not refused then pass through the sum state, which reads the entries
// one after another from the single ring read port; every item ends in the finish state
// input is accepted only in the idle state, so a new item is taken only after the last
// one has been loaded into the output register; a held result stalls input
// reset: front and rear pointers zero, capacity min(DEPTH,64), ring contents undefined
`timescale 1ns / 1ps
`include "assert_macros.svh"

module circular_queue_window_sum_unit #(
	parameter int DEPTH = cqws_pkg::DefDepth
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  cqws_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output cqws_pkg::out_item_t                 out_item,
	input  logic                                cfg_we,
	input  logic [cqws_pkg::CapWidth-1:0]       cfg_wdata
);

	localparam int PW = $clog2(DEPTH + 1);
	localparam int CW = ((PW > cqws_pkg::CapWidth) ? PW : cqws_pkg::CapWidth) + 2;
	localparam int CapReset = (DEPTH < 64) ? DEPTH : 64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SUM,
		ST_FIN
	} state_t;

	state_t                              state_q;
	logic [PW-1:0]                       front_q;
	logic [PW-1:0]                       rear_q;
	logic [PW-1:0]                       pos_q;
	logic [cqws_pkg::CapWidth-1:0]       capacity_q;
	logic [cqws_pkg::CountWidth-1:0]     remain_q;
	logic                                dir_fwd_q;
	logic                                ok_q;
	logic                                rd_pend_s1;
	logic                                out_valid_q;
	cqws_pkg::out_item_t                 out_item_q;

	cqws_pkg::mode_t                     mode_q;
	logic [cqws_pkg::DataWidth-1:0]      value_q;
	logic [cqws_pkg::CountWidth-1:0]     count_q;
	logic [cqws_pkg::DataWidth-1:0]      acc_q;

	logic [CW-1:0]                       slots_w;
	logic [CW-1:0]                       held_w;
	logic [cqws_pkg::CountWidth-1:0]     len_w;
	logic [CW-1:0]                       rw_sum_w;
	logic [PW-1:0]                       pos_rw_w;
	logic                                pos_ok_w;
	logic [cqws_pkg::CountWidth-1:0]     set_cnt_w;
	logic [PW-1:0]                       set_front_w;
	logic [cqws_pkg::CapWidth-1:0]       cap_sat_w;
	logic                                in_xfer_w;

	logic                                mem_we;
	logic [PW-1:0]                       mem_waddr;
	logic [PW-1:0]                       mem_raddr;
	logic [cqws_pkg::DataWidth-1:0]      mem_rdata;

	// one step forward around the ring
	function automatic logic [PW-1:0] step_fwd(input logic [PW-1:0] idx,
		input logic [CW-1:0] slots);
		logic [CW-1:0] nxt;
		nxt = CW'(idx) + CW'(1);
		return (nxt == slots) ? '0 : PW'(nxt);
	endfunction

	// one step back around the ring
	function automatic logic [PW-1:0] step_bwd(input logic [PW-1:0] idx,
		input logic [CW-1:0] slots);
		logic [CW-1:0] prv;
		prv = (idx == '0) ? (slots - CW'(1)) : (CW'(idx) - CW'(1));
		return PW'(prv);
	endfunction

	// ring size and held length
	always_comb begin
		slots_w = CW'(capacity_q) + CW'(1);
		if (rear_q >= front_q) begin
			held_w = CW'(rear_q) - CW'(front_q);
		end else begin
			held_w = CW'(rear_q) + slots_w - CW'(front_q);
		end
		len_w = held_w[cqws_pkg::CountWidth-1:0];
	end

	// slot of a 1-based position, wraps at most once
	always_comb begin
		rw_sum_w = CW'(front_q) + CW'(count_q) - CW'(1);
		if (rw_sum_w >= slots_w) begin
			pos_rw_w = PW'(rw_sum_w - slots_w);
		end else begin
			pos_rw_w = PW'(rw_sum_w);
		end
		pos_ok_w = (count_q != '0) && (CW'(count_q) <= held_w);
	end

	// new front pointer for set length, count saturated at capacity
	always_comb begin
		set_cnt_w = (count_q > capacity_q) ? capacity_q : count_q;
		if (CW'(rear_q) >= CW'(set_cnt_w)) begin
			set_front_w = PW'(CW'(rear_q) - CW'(set_cnt_w));
		end else begin
			set_front_w = PW'(CW'(rear_q) + slots_w - CW'(set_cnt_w));
		end
	end

	// capacity write saturates at DEPTH
	assign cap_sat_w = (CW'(cfg_wdata) > CW'(DEPTH)) ? cqws_pkg::CapWidth'(DEPTH) : cfg_wdata;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer_w = in_valid && in_ready;

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rear_q;
		if (state_q == ST_EXEC) begin
			if (mode_q == cqws_pkg::MODE_ENQ) begin
				mem_we = 1'b1;
			end else if (mode_q == cqws_pkg::MODE_WR_POS) begin
				mem_we    = pos_ok_w;
				mem_waddr = pos_rw_w;
			end
		end
		mem_raddr = pos_q;
	end

	cqws_ram #(
		.WIDTH(cqws_pkg::DataWidth),
		.DEPTH(DEPTH + 1)
	) u_ring (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(value_q),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// control state machine and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			rear_q      <= '0;
			pos_q       <= '0;
			capacity_q  <= cqws_pkg::CapWidth'(CapReset);
			remain_q    <= '0;
			dir_fwd_q   <= 1'b1;
			ok_q        <= 1'b0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			// output register: load a finished item, else clear on transfer
			if ((state_q == ST_FIN) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_pend_s1 <= (state_q == ST_SUM) && (remain_q != '0);
			case (state_q)
				ST_IDLE: begin
					if (in_xfer_w) begin
						ok_q    <= 1'b1;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (mode_q)
						cqws_pkg::MODE_ENQ: begin
							if (step_fwd(rear_q, slots_w) == front_q) begin
								front_q <= step_fwd(front_q, slots_w);
							end
							rear_q  <= step_fwd(rear_q, slots_w);
							state_q <= ST_FIN;
						end
						cqws_pkg::MODE_DEQ: begin
							if (held_w == '0) begin
								ok_q    <= 1'b0;
								state_q <= ST_FIN;
							end else begin
								pos_q    <= front_q;
								front_q  <= step_fwd(front_q, slots_w);
								remain_q <= cqws_pkg::CountWidth'(1);
								state_q  <= ST_SUM;
							end
						end
						cqws_pkg::MODE_POP: begin
							if (held_w == '0) begin
								ok_q    <= 1'b0;
								state_q <= ST_FIN;
							end else begin
								pos_q    <= step_bwd(rear_q, slots_w);
								rear_q   <= step_bwd(rear_q, slots_w);
								remain_q <= cqws_pkg::CountWidth'(1);
								state_q  <= ST_SUM;
							end
						end
						cqws_pkg::MODE_SUM_FRONT, cqws_pkg::MODE_SUM_REAR: begin
							if (held_w < CW'(count_q)) begin
								ok_q    <= 1'b0;
								state_q <= ST_FIN;
							end else begin
								dir_fwd_q <= (mode_q == cqws_pkg::MODE_SUM_FRONT);
								pos_q     <= (mode_q == cqws_pkg::MODE_SUM_FRONT) ?
									front_q : step_bwd(rear_q, slots_w);
								remain_q  <= count_q;
								state_q   <= ST_SUM;
							end
						end
						cqws_pkg::MODE_RD_POS: begin
							if (!pos_ok_w) begin
								ok_q    <= 1'b0;
								state_q <= ST_FIN;
							end else begin
								pos_q    <= pos_rw_w;
								remain_q <= cqws_pkg::CountWidth'(1);
								state_q  <= ST_SUM;
							end
						end
						cqws_pkg::MODE_WR_POS: begin
							ok_q    <= pos_ok_w;
							state_q <= ST_FIN;
						end
						cqws_pkg::MODE_SET_LEN: begin
							front_q <= set_front_w;
							state_q <= ST_FIN;
						end
						default: begin
							ok_q    <= 1'b0;
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_SUM: begin
					// issue one read a cycle, drain the last one before finishing
					if (remain_q != '0) begin
						pos_q    <= dir_fwd_q ? step_fwd(pos_q, slots_w) :
							step_bwd(pos_q, slots_w);
						remain_q <= remain_q - cqws_pkg::CountWidth'(1);
					end else if (!rd_pend_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_item_q.data      <= acc_q;
						out_item_q.ok        <= ok_q;
						out_item_q.length    <= len_w;
						out_item_q.empty_res <= (held_w == '0);
						out_item_q.full_res  <= (CW'(len_w) == CW'(capacity_q));
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// capacity write empties the queue
			if (cfg_we) begin
				capacity_q <= cap_sat_w;
				front_q    <= '0;
				rear_q     <= '0;
			end
		end
	end

	// item payload and sum accumulator
	always_ff @(posedge clk) begin
		if (in_xfer_w) begin
			mode_q  <= in_item.mode;
			value_q <= in_item.value;
			count_q <= in_item.count;
			acc_q   <= '0;
		end else if (rd_pend_s1) begin
			acc_q <= acc_q + mem_rdata;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`CQWS_ASSERT(a_ptr_range, (CW'(front_q) < slots_w) && (CW'(rear_q) < slots_w), "pointer beyond ring")
	`CQWS_ASSERT(a_len_cap, held_w <= CW'(capacity_q), "held length above capacity")
	`CQWS_ASSERT_NEXT(a_accept_exec, in_xfer_w, state_q == ST_EXEC, "accepted item not executed")
	`CQWS_ASSERT(a_read_in_sum, !rd_pend_s1 || (state_q == ST_SUM), "memory read outside walk")

endmodule

// ===== verif/circular_queue_window_sum_unit_tb.sv =====
`timescale 1ns / 1ps

module circular_queue_window_sum_unit_tb;
	import cqws_pkg::*;

	localparam int PlanRows   = 30;
	localparam int Phases     = 8;
	localparam int PhaseOps   = 150;
	localparam int HoldCycles = 400;
	localparam int DrainWait  = 80;
	localparam int Limit      = 1000000;
	localparam int MaxCap     = 64;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	logic      cfg_we = 1'b0;
	logic [CapWidth-1:0] cfg_wdata = '0;

	// receiver control, driven from the stimulus process
	int   stall_pct = 0;
	logic hold_req = 1'b0;
	int   hold_left = 0;

	int send_idle_pct = 0;
	int fail_count = 0;
	int cycle_count = 0;

	// shadow ring: contents, which slots were ever written, pointers
	logic [DataWidth-1:0] ring_mem [MaxCap+1];
	bit                   ring_set [MaxCap+1];
	int unsigned          front_ptr = 0;
	int unsigned          rear_ptr = 0;
	int unsigned          cap_now = MaxCap;
	int unsigned          nslot = MaxCap + 1;

	out_item_t pending_results [$];

	// one row of the directed sequence: a capacity write or an operation
	typedef struct packed {
		logic                 is_cfg;
		logic [CapWidth-1:0]  cap_val;
		mode_t                mode;
		logic [DataWidth-1:0] value;
		logic [CountWidth-1:0] count;
		logic                 typed;
		logic [DataWidth-1:0] data;
		logic                 ok;
		logic [CountWidth-1:0] length;
		logic                 empty_res;
		logic                 full_res;
	} plan_row_t;

	plan_row_t plan [PlanRows] = '{
		'{1'b0, 7'd0, MODE_DEQ,       16'h0000, 7'd0,   1'b1, 16'h0000, 1'b0, 7'd0,  1'b1, 1'b0},
		'{1'b0, 7'd0, MODE_POP,       16'h0000, 7'd0,   1'b1, 16'h0000, 1'b0, 7'd0,  1'b1, 1'b0},
		'{1'b0, 7'd0, MODE_SUM_FRONT, 16'h0000, 7'd0,   1'b1, 16'h0000, 1'b1, 7'd0,  1'b1, 1'b0},
		'{1'b0, 7'd0, MODE_SUM_REAR,  16'h0000, 7'd1,   1'b1, 16'h0000, 1'b0, 7'd0,  1'b1, 1'b0},
		'{1'b0, 7'd0, MODE_RD_POS,    16'h0000, 7'd0,   1'b1, 16'h0000, 1'b0, 7'd0,  1'b1, 1'b0},
		'{1'b0, 7'd0, MODE_ENQ,       16'hFFFF, 7'd0,   1'b1, 16'h0000, 1'b1, 7'd1,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_ENQ,       16'h0000, 7'd127, 1'b1, 16'h0000, 1'b1, 7'd2,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_ENQ,       16'h8001, 7'd64,  1'b1, 16'h0000, 1'b1, 7'd3,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_SUM_FRONT, 16'h0000, 7'd3,   1'b1, 16'h8000, 1'b1, 7'd3,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_SUM_REAR,  16'h0000, 7'd2,   1'b1, 16'h8001, 1'b1, 7'd3,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_RD_POS,    16'h0000, 7'd1,   1'b1, 16'hFFFF, 1'b1, 7'd3,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_RD_POS,    16'h0000, 7'd4,   1'b1, 16'h0000, 1'b0, 7'd3,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_WR_POS,    16'h1234, 7'd2,   1'b1, 16'h0000, 1'b1, 7'd3,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_WR_POS,    16'h5555, 7'd0,   1'b1, 16'h0000, 1'b0, 7'd3,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_RD_POS,    16'h0000, 7'd2,   1'b1, 16'h1234, 1'b1, 7'd3,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_SET_LEN,   16'h0000, 7'd127, 1'b1, 16'h0000, 1'b1, 7'd64, 1'b0, 1'b1},
		'{1'b0, 7'd0, MODE_SET_LEN,   16'h0000, 7'd2,   1'b0, 16'h0000, 1'b0, 7'd0,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_DEQ,       16'h0000, 7'd0,   1'b1, 16'h1234, 1'b1, 7'd1,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_POP,       16'h0000, 7'd0,   1'b1, 16'h8001, 1'b1, 7'd0,  1'b1, 1'b0},
		'{1'b0, 7'd0, MODE_DEQ,       16'h0000, 7'd0,   1'b1, 16'h0000, 1'b0, 7'd0,  1'b1, 1'b0},
		'{1'b1, 7'd2, MODE_ENQ,       16'h0000, 7'd0,   1'b0, 16'h0000, 1'b0, 7'd0,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_ENQ,       16'h0005, 7'd0,   1'b1, 16'h0000, 1'b1, 7'd1,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_ENQ,       16'h0006, 7'd0,   1'b1, 16'h0000, 1'b1, 7'd2,  1'b0, 1'b1},
		'{1'b0, 7'd0, MODE_ENQ,       16'h0007, 7'd0,   1'b1, 16'h0000, 1'b1, 7'd2,  1'b0, 1'b1},
		'{1'b0, 7'd0, MODE_SUM_FRONT, 16'h0000, 7'd2,   1'b0, 16'h0000, 1'b0, 7'd0,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_DEQ,       16'h0000, 7'd0,   1'b1, 16'h0006, 1'b1, 7'd1,  1'b0, 1'b0},
		'{1'b1, 7'd0, MODE_ENQ,       16'h0000, 7'd0,   1'b0, 16'h0000, 1'b0, 7'd0,  1'b0, 1'b0},
		'{1'b0, 7'd0, MODE_ENQ,       16'h0009, 7'd0,   1'b1, 16'h0000, 1'b1, 7'd0,  1'b1, 1'b1},
		'{1'b0, 7'd0, MODE_DEQ,       16'h0000, 7'd0,   1'b1, 16'h0000, 1'b0, 7'd0,  1'b1, 1'b1},
		'{1'b0, 7'd0, MODE_SUM_FRONT, 16'h0000, 7'd0,   1'b1, 16'h0000, 1'b1, 7'd0,  1'b1, 1'b1}
	};

	logic [CapWidth-1:0] phase_caps [Phases] = '{
		7'd64, 7'd3, 7'd127, 7'd1, 7'd0, 7'd40, 7'd64, 7'd64
	};

	circular_queue_window_sum_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// ring pointer arithmetic over the current slot count
	function automatic int unsigned next_slot(input int unsigned i);
		return (i + 1) % nslot;
	endfunction

	function automatic int unsigned prev_slot(input int unsigned i);
		return (i + nslot - 1) % nslot;
	endfunction

	function automatic int unsigned held_now();
		return (rear_ptr + nslot - front_ptr) % nslot;
	endfunction

	// capacity write: saturate, resize the ring, empty the queue
	function automatic void load_capacity(input logic [CapWidth-1:0] v);
		cap_now = (v > MaxCap) ? MaxCap : v;
		nslot = cap_now + 1;
		front_ptr = 0;
		rear_ptr = 0;
	endfunction

	// true when the operation would read a slot that was never written
	function automatic bit hits_unwritten(input in_item_t it);
		int unsigned len, pos, k;
		len = held_now();
		case (it.mode)
			MODE_DEQ: return len != 0 && !ring_set[front_ptr];
			MODE_POP: return len != 0 && !ring_set[prev_slot(rear_ptr)];
			MODE_SUM_FRONT, MODE_SUM_REAR: begin
				if (len < it.count)
					return 1'b0;
				pos = (it.mode == MODE_SUM_FRONT) ? front_ptr : prev_slot(rear_ptr);
				for (k = 0; k < it.count; k++) begin
					if (!ring_set[pos])
						return 1'b1;
					pos = (it.mode == MODE_SUM_FRONT) ? next_slot(pos) : prev_slot(pos);
				end
				return 1'b0;
			end
			MODE_RD_POS:
				return it.count != 0 && it.count <= len
					&& !ring_set[(front_ptr + it.count - 1) % nslot];
			default: return 1'b0;
		endcase
	endfunction

	// apply one operation to the shadow ring and return its result
	function automatic out_item_t apply_queue_op(input in_item_t it);
		out_item_t r;
		int unsigned len, pos, n, k;
		logic [DataWidth-1:0] acc;
		r = '0;
		r.ok = 1'b1;
		acc = '0;
		len = held_now();
		n = it.count;
		case (it.mode)
			MODE_ENQ: begin
				if (next_slot(rear_ptr) == front_ptr)
					front_ptr = next_slot(front_ptr);
				ring_mem[rear_ptr] = it.value;
				ring_set[rear_ptr] = 1'b1;
				rear_ptr = next_slot(rear_ptr);
			end
			MODE_DEQ: begin
				if (len == 0) begin
					r.ok = 1'b0;
				end else begin
					acc = ring_mem[front_ptr];
					front_ptr = next_slot(front_ptr);
				end
			end
			MODE_POP: begin
				if (len == 0) begin
					r.ok = 1'b0;
				end else begin
					rear_ptr = prev_slot(rear_ptr);
					acc = ring_mem[rear_ptr];
				end
			end
			MODE_SUM_FRONT, MODE_SUM_REAR: begin
				if (len < n) begin
					r.ok = 1'b0;
				end else begin
					pos = (it.mode == MODE_SUM_FRONT) ? front_ptr : prev_slot(rear_ptr);
					for (k = 0; k < n; k++) begin
						acc = acc + ring_mem[pos];
						pos = (it.mode == MODE_SUM_FRONT) ? next_slot(pos) : prev_slot(pos);
					end
				end
			end
			MODE_RD_POS, MODE_WR_POS: begin
				if (n == 0 || n > len) begin
					r.ok = 1'b0;
				end else begin
					pos = (front_ptr + n - 1) % nslot;
					if (it.mode == MODE_RD_POS) begin
						acc = ring_mem[pos];
					end else begin
						ring_mem[pos] = it.value;
						ring_set[pos] = 1'b1;
					end
				end
			end
			default: begin
				if (n > cap_now)
					n = cap_now;
				front_ptr = (nslot + rear_ptr - n) % nslot;
			end
		endcase
		len = held_now();
		r.data = acc;
		r.length = 7'(len);
		r.empty_res = (len == 0);
		r.full_res = (len == cap_now);
		return r;
	endfunction

	// random operation, mostly well formed against the current length
	function automatic in_item_t draw_item();
		in_item_t it;
		int unsigned len;
		len = held_now();
		it.value = 16'($urandom);
		if ($urandom_range(0, 99) < 40)
			it.mode = MODE_ENQ;
		else
			it.mode = mode_t'(3'($urandom_range(1, 7)));
		if ($urandom_range(0, 9) == 0)
			it.count = 7'($urandom);
		else if (it.mode == MODE_SET_LEN)
			it.count = 7'($urandom_range(0, cap_now + 1));
		else
			it.count = 7'($urandom_range(0, len + 1));
		if (hits_unwritten(it))
			it.mode = MODE_ENQ;
		return it;
	endfunction

	// offer one operation and hold it until the input transfer
	task automatic send_op(input in_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	// drain, then write the capacity register while the block is idle
	task automatic write_capacity(input logic [CapWidth-1:0] v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		load_capacity(v);
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: result %h with nothing expected", $time, got);
			fail_count++;
			return;
		end
		want = pending_results.pop_front();
		if (got.data !== want.data) begin
			$display("%0t: data expected %h got %h", $time, want.data, got.data);
			fail_count++;
		end
		if (got.ok !== want.ok) begin
			$display("%0t: ok expected %b got %b", $time, want.ok, got.ok);
			fail_count++;
		end
		if (got.length !== want.length) begin
			$display("%0t: length expected %0d got %0d", $time, want.length, got.length);
			fail_count++;
		end
		if (got.empty_res !== want.empty_res) begin
			$display("%0t: empty_res expected %b got %b", $time, want.empty_res,
				got.empty_res);
			fail_count++;
		end
		if (got.full_res !== want.full_res) begin
			$display("%0t: full_res expected %b got %b", $time, want.full_res,
				got.full_res);
			fail_count++;
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_req) begin
			hold_left <= HoldCycles;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// output transfer check
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_result(out_item);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == Limit) begin
			$display("FAILURE");
			$finish;
		end
	end

	// stimulus
	initial begin
		in_item_t  it;
		out_item_t want;
		int        p, k;
		for (k = 0; k <= MaxCap; k++) begin
			ring_mem[k] = '0;
			ring_set[k] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sequence
		for (k = 0; k < PlanRows; k++) begin
			if (plan[k].is_cfg) begin
				write_capacity(plan[k].cap_val);
			end else begin
				it.mode = plan[k].mode;
				it.value = plan[k].value;
				it.count = plan[k].count;
				want = apply_queue_op(it);
				if (plan[k].typed) begin
					want.data = plan[k].data;
					want.ok = plan[k].ok;
					want.length = plan[k].length;
					want.empty_res = plan[k].empty_res;
					want.full_res = plan[k].full_res;
				end
				pending_results.push_back(want);
				send_op(it);
			end
		end

		// random phases, each with its own capacity and idling pattern
		for (p = 0; p < Phases; p++) begin
			if (p == 6)
				phase_caps[p] = 7'($urandom);
			write_capacity(phase_caps[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct <= 0;  end
				1: begin send_idle_pct = 88; stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  stall_pct <= 88; end
				default: begin send_idle_pct = 26; stall_pct <= 26; end
			endcase
			// long receiver hold-off so the block backs up into its input
			if (p == 0) begin
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			for (k = 0; k < PhaseOps; k++) begin
				it = draw_item();
				pending_results.push_back(apply_queue_op(it));
				send_op(it);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainWait) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
